>>> hw/rtl/mvs_pkg.sv
// ----------------------------------------------------------------------------
// mvs_pkg
// Shared types and constants for the multiversion timestamp-ordering store.
// ----------------------------------------------------------------------------
package mvs_pkg;

	localparam int KEY_COUNT    = 1024;
	localparam int MAX_VERSIONS = 8;
	localparam int KEY_W        = 10;
	localparam int KIDX_W       = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int STAMP_W      = 31;
	localparam int VALUE_W      = 32;
	localparam int CNT_W        = 4;
	localparam int SLOT_W       = $clog2(MAX_VERSIONS + 1);

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_CHECK = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NONE     = 2'd1;
	localparam logic [1:0] ST_CONFLICT = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic [STAMP_W-1:0] wstamp;
		logic [STAMP_W-1:0] rstamp;
		logic [VALUE_W-1:0] value;
	} version_t;

	typedef version_t [MAX_VERSIONS-1:0] row_t;

	// Row write request from the update logic to the memory.
	typedef struct packed {
		logic              en;
		logic [KIDX_W-1:0] idx;
		row_t              row;
		logic [CNT_W-1:0]  cnt;
	} row_wr_t;

endpackage

>>> hw/rtl/mvs_row_mem.sv
// ----------------------------------------------------------------------------
// mvs_row_mem
// One wide row per key: all versions and the version count. After reset a
// clearing pass writes every row with the stamp-zero version and a count of
// one, one key per cycle.
// ----------------------------------------------------------------------------
module mvs_row_mem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [mvs_pkg::KIDX_W-1:0] rd_idx,
	output mvs_pkg::row_t             rd_row,
	output logic [mvs_pkg::CNT_W-1:0] rd_cnt,
	input  mvs_pkg::row_wr_t          wr,
	output logic                      init_busy
);

	mvs_pkg::row_t            mem [mvs_pkg::KEY_COUNT];
	logic [mvs_pkg::CNT_W-1:0] cnt_mem [mvs_pkg::KEY_COUNT];
	logic [mvs_pkg::CNT_W-1:0] cnt_rd_q;
	logic [mvs_pkg::KIDX_W-1:0] clr_idx_q;
	logic                     clr_busy_q;

	// Synchronous row memory with registered read; the clearing pass owns the
	// write port until every key holds its initial row.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q]     <= '0;
			cnt_mem[clr_idx_q] <= mvs_pkg::CNT_W'(1);
		end else if (wr.en) begin
			mem[wr.idx]     <= wr.row;
			cnt_mem[wr.idx] <= wr.cnt;
		end
		if (rd_en) begin
			rd_row   <= mem[rd_idx];
			cnt_rd_q <= cnt_mem[rd_idx];
		end
	end

	// Clearing pass: walks every key once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == mvs_pkg::KIDX_W'(mvs_pkg::KEY_COUNT - 1))
				clr_busy_q <= 1'b0;
		end
	end

	assign init_busy = clr_busy_q;
	assign rd_cnt    = cnt_rd_q;

endmodule

>>> hw/rtl/mvs_update.sv
// ----------------------------------------------------------------------------
// mvs_update
// Selects the version for a request from a full row and builds the result
// and the modified row.
// ----------------------------------------------------------------------------
module mvs_update (
	input  logic [1:0]                  kind,
	input  logic                        key_ok,
	input  logic [mvs_pkg::STAMP_W-1:0] ts,
	input  logic [mvs_pkg::VALUE_W-1:0] wval,
	input  mvs_pkg::row_t               row_in,
	input  logic [mvs_pkg::CNT_W-1:0]   cnt_in,
	output logic                        wr_en,
	output mvs_pkg::row_t               row_out,
	output logic [mvs_pkg::CNT_W-1:0]   cnt_out,
	output logic [1:0]                  status,
	output logic [mvs_pkg::VALUE_W-1:0] rval
);

	logic [mvs_pkg::SLOT_W-1:0] cnt, s;
	logic [mvs_pkg::MAX_VERSIONS-1:0] hit;
	mvs_pkg::row_t row_eff;
	mvs_pkg::version_t sel;
	logic found;

	always_comb begin
		cnt = (cnt_in > mvs_pkg::CNT_W'(mvs_pkg::MAX_VERSIONS)) ?
			mvs_pkg::SLOT_W'(mvs_pkg::MAX_VERSIONS) : mvs_pkg::SLOT_W'(cnt_in);
		// Every row holds valid versions below its count after the clearing pass.
		row_eff = row_in;
		for (int i = 0; i < mvs_pkg::MAX_VERSIONS; i++)
			hit[i] = (mvs_pkg::SLOT_W'(i) < cnt) && (row_eff[i].wstamp <= ts);
		s = cnt;
		for (int i = mvs_pkg::MAX_VERSIONS - 1; i >= 0; i--)
			if (hit[i])
				s = mvs_pkg::SLOT_W'(i);
		found = |hit;
		sel = '0;
		for (int i = 0; i < mvs_pkg::MAX_VERSIONS; i++)
			if (s == mvs_pkg::SLOT_W'(i))
				sel = row_eff[i];
	end

	always_comb begin
		wr_en   = 1'b0;
		row_out = row_eff;
		cnt_out = cnt_in;
		status  = mvs_pkg::ST_OK;
		rval    = '0;
		if (!key_ok) begin
			if (kind == mvs_pkg::KIND_READ)
				status = mvs_pkg::ST_NONE;
			else if (kind == mvs_pkg::KIND_WRITE)
				status = mvs_pkg::ST_FULL;
		end else if (kind == mvs_pkg::KIND_READ) begin
			if (found) begin
				rval = sel.value;
				if (ts > sel.rstamp) begin
					wr_en = 1'b1;
					for (int i = 0; i < mvs_pkg::MAX_VERSIONS; i++)
						if (s == mvs_pkg::SLOT_W'(i))
							row_out[i].rstamp = ts;
				end
			end else begin
				status = mvs_pkg::ST_NONE;
			end
		end else if (kind == mvs_pkg::KIND_CHECK) begin
			if (found && sel.rstamp > ts)
				status = mvs_pkg::ST_CONFLICT;
		end else if (kind == mvs_pkg::KIND_WRITE) begin
			if (found && sel.wstamp == ts) begin
				wr_en = 1'b1;
				for (int i = 0; i < mvs_pkg::MAX_VERSIONS; i++)
					if (s == mvs_pkg::SLOT_W'(i))
						row_out[i].value = wval;
			end else if (cnt >= mvs_pkg::SLOT_W'(mvs_pkg::MAX_VERSIONS)) begin
				status = mvs_pkg::ST_FULL;
			end else begin
				// Shift older versions down one slot and insert at the hit.
				wr_en   = 1'b1;
				cnt_out = mvs_pkg::CNT_W'(cnt + 1'b1);
				for (int i = 0; i < mvs_pkg::MAX_VERSIONS; i++) begin
					if (mvs_pkg::SLOT_W'(i) == s) begin
						row_out[i].wstamp = ts;
						row_out[i].rstamp = ts;
						row_out[i].value  = wval;
					end else if (i > 0 && mvs_pkg::SLOT_W'(i) > s &&
							mvs_pkg::SLOT_W'(i) <= cnt) begin
						row_out[i] = row_eff[(i > 0) ? i - 1 : 0];
					end
				end
			end
		end
	end

endmodule

>>> hw/rtl/mvcc_version_store_top.sv
// ----------------------------------------------------------------------------
// mvcc_version_store_top
// Multiversion timestamp-ordering version store.
// ----------------------------------------------------------------------------
// Each request first reads the key's full version row from the row memory,
// then selects the version, updates the row and writes it back. No new
// request is taken during the update, so a row's write-back lands before the
// next read; the result is held in an output register after the update. While
// a result waits there under out_stall, the input is stalled as well. After
// reset a clearing pass writes every key's row, and in_stall stays high until
// it is done.
module mvcc_version_store_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [9:0]  key,
	input  logic [30:0] txn_stamp,
	input  logic [31:0] write_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] read_value
);

	logic        busy_s1;
	logic [1:0]  kind_s1;
	logic        key_ok_s1;
	logic [30:0] ts_s1;
	logic [31:0] wval_s1;
	mvs_pkg::row_t rd_row, new_row;
	logic [mvs_pkg::CNT_W-1:0] rd_cnt, new_cnt;
	logic        upd_wr;
	logic [1:0]  upd_status;
	logic [31:0] upd_rval;
	logic [mvs_pkg::KIDX_W-1:0] idx_s1;
	mvs_pkg::row_wr_t wr;
	logic        accept;
	logic        init_busy;

	// Input stalls during clearing, while stage one is busy, or while a stalled result waits in the output reg.
	assign in_stall = init_busy || busy_s1 || (out_valid && out_stall);
	assign accept   = in_valid && !in_stall;

	mvs_row_mem u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_idx    (mvs_pkg::KIDX_W'(key)),
		.rd_row    (rd_row),
		.rd_cnt    (rd_cnt),
		.wr        (wr),
		.init_busy (init_busy)
	);

	mvs_update u_upd (
		.kind    (kind_s1),
		.key_ok  (key_ok_s1),
		.ts      (ts_s1),
		.wval    (wval_s1),
		.row_in  (rd_row),
		.cnt_in  (rd_cnt),
		.wr_en   (upd_wr),
		.row_out (new_row),
		.cnt_out (new_cnt),
		.status  (upd_status),
		.rval    (upd_rval)
	);

	always_comb begin
		wr.en  = busy_s1 && upd_wr;
		wr.idx = idx_s1;
		wr.row = new_row;
		wr.cnt = new_cnt;
	end

	// Request fields held for the update cycle; the result is captured in the output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind;
			key_ok_s1 <= 32'(key) < mvs_pkg::KEY_COUNT;
			idx_s1    <= mvs_pkg::KIDX_W'(key);
			ts_s1     <= txn_stamp;
			wval_s1   <= write_value;
		end
		if (busy_s1) begin
			status     <= upd_status;
			read_value <= upd_rval;
		end
	end

	// Control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			busy_s1 <= accept;
			if (busy_s1)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

endmodule

>>> hw/rtl/mvs_checker.sv
// ----------------------------------------------------------------------------
// mvs_checker
// Port-level checks on the version store.
// ----------------------------------------------------------------------------
module mvs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [31:0] read_value
);

	// An accepted request raises out_valid after its row read and update.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 out_valid)
		else $error("result missing");

	// Back-to-back acceptance is impossible.
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted twice");

	// A result with a failure status carries a zero value.
	a_rval: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != mvs_pkg::ST_OK |-> read_value == 32'd0)
		else $error("value on failure");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(read_value))
		else $error("result changed");

endmodule

bind mvcc_version_store_top mvs_checker u_chk (.*);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the version store. A directed table walks reset
// values, stamp extremes, conflicts, overwrites, full lists and the unused
// kind, then random traffic on a few hot keys checks every result against an
// in-bench model of the version lists.
// ----------------------------------------------------------------------------
module tb_top;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [9:0]  key;
	logic [30:0] txn_stamp;
	logic [31:0] write_value;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [31:0] read_value;

	mvcc_version_store_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .key(key), .txn_stamp(txn_stamp), .write_value(write_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .read_value(read_value)
	);

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 1130;

	// Shadow copy of the version lists.
	logic [mvs_pkg::STAMP_W-1:0] shadow_wstamp [mvs_pkg::KEY_COUNT][mvs_pkg::MAX_VERSIONS];
	logic [mvs_pkg::STAMP_W-1:0] shadow_rstamp [mvs_pkg::KEY_COUNT][mvs_pkg::MAX_VERSIONS];
	logic [mvs_pkg::VALUE_W-1:0] shadow_value  [mvs_pkg::KEY_COUNT][mvs_pkg::MAX_VERSIONS];
	int                          shadow_count  [mvs_pkg::KEY_COUNT];

	logic [1:0]  pending_status [$];
	logic [31:0] pending_value  [$];
	int          mismatch_count;
	bit          stim_done;
	bit          hold_rx;

	typedef struct {
		logic [1:0]  k;
		logic [9:0]  ky;
		logic [30:0] ts;
		logic [31:0] wv;
		bit          typed;
		logic [1:0]  st;
		logic [31:0] rv;
	} stim_row_t;

	// Work out the result of one request and update the shadow lists.
	function automatic void apply_request(input logic [1:0] k, input logic [9:0] ky,
		input logic [30:0] ts, input logic [31:0] wv,
		output logic [1:0] st, output logic [31:0] rv);
		int cnt;
		int s;
		st = mvs_pkg::ST_OK;
		rv = '0;
		if (k == KIND_UNUSED) return;
		cnt = shadow_count[ky];
		s = cnt;
		for (int i = cnt - 1; i >= 0; i--)
			if (shadow_wstamp[ky][i] <= ts) s = i;
		if (k == mvs_pkg::KIND_READ) begin
			if (s < cnt) begin
				if (ts > shadow_rstamp[ky][s]) shadow_rstamp[ky][s] = ts;
				rv = shadow_value[ky][s];
			end else begin
				st = mvs_pkg::ST_NONE;
			end
		end else if (k == mvs_pkg::KIND_CHECK) begin
			if (s < cnt && shadow_rstamp[ky][s] > ts) st = mvs_pkg::ST_CONFLICT;
		end else if (s < cnt && shadow_wstamp[ky][s] == ts) begin
			shadow_value[ky][s] = wv;
		end else if (cnt >= mvs_pkg::MAX_VERSIONS) begin
			st = mvs_pkg::ST_FULL;
		end else begin
			for (int j = cnt; j > s; j--) begin
				shadow_wstamp[ky][j] = shadow_wstamp[ky][j-1];
				shadow_rstamp[ky][j] = shadow_rstamp[ky][j-1];
				shadow_value[ky][j]  = shadow_value[ky][j-1];
			end
			shadow_wstamp[ky][s] = ts;
			shadow_rstamp[ky][s] = ts;
			shadow_value[ky][s]  = wv;
			shadow_count[ky] = cnt + 1;
		end
	endfunction

	always #10 clk = ~clk;

	// Offer one request, wait for its acceptance, and queue its expected result.
	task automatic send_request(input logic [1:0] k, input logic [9:0] ky,
		input logic [30:0] ts, input logic [31:0] wv,
		input bit typed, input logic [1:0] tst, input logic [31:0] trv);
		logic [1:0]  st;
		logic [31:0] rv;
		int gap;
		gap = $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		key         <= ky;
		txn_stamp   <= ts;
		write_value <= wv;
		apply_request(k, ky, ts, wv, st, rv);
		if (typed && (st !== tst || rv !== trv))
			$display("table row disagrees with model: key %0d", ky);
		pending_status.insert(pending_status.size(), typed ? tst : st);
		pending_value.insert(pending_value.size(), typed ? trv : rv);
		do @(posedge clk); while (in_stall);
	endtask

	// Stimulus: directed table, then random traffic.
	initial begin
		stim_row_t tbl [$];
		logic [1:0]  rk;
		logic [9:0]  rkey;
		logic [30:0] rts;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = mvs_pkg::KIND_READ;
		key = '0;
		txn_stamp = '0;
		write_value = '0;
		stim_done = 1'b0;
		for (int i = 0; i < mvs_pkg::KEY_COUNT; i++) begin
			shadow_count[i] = 1;
			shadow_wstamp[i][0] = '0;
			shadow_rstamp[i][0] = '0;
			shadow_value[i][0]  = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tbl.insert(tbl.size(), '{mvs_pkg::KIND_READ, 10'd0, 31'd0, 32'd0, 1,
			mvs_pkg::ST_OK, 32'd0});
		tbl.insert(tbl.size(), '{mvs_pkg::KIND_READ, 10'd1023, 31'h7FFFFFFF, 32'd0, 1,
			mvs_pkg::ST_OK, 32'd0});
		tbl.insert(tbl.size(), '{mvs_pkg::KIND_CHECK, 10'd1023, 31'd5, 32'd0, 1,
			mvs_pkg::ST_CONFLICT, 32'd0});
		tbl.insert(tbl.size(), '{mvs_pkg::KIND_CHECK, 10'd0, 31'd0, 32'd0, 1,
			mvs_pkg::ST_OK, 32'd0});
		tbl.insert(tbl.size(), '{mvs_pkg::KIND_WRITE, 10'd0, 31'd0, 32'hFFFFFFFF, 1,
			mvs_pkg::ST_OK, 32'd0});
		tbl.insert(tbl.size(), '{mvs_pkg::KIND_READ, 10'd0, 31'd9, 32'd0, 1,
			mvs_pkg::ST_OK, 32'hFFFFFFFF});
		tbl.insert(tbl.size(), '{KIND_UNUSED, 10'd3, 31'h7FFFFFFF, 32'hFFFFFFFF, 1,
			mvs_pkg::ST_OK, 32'd0});
		tbl.insert(tbl.size(), '{mvs_pkg::KIND_WRITE, 10'd5, 31'h7FFFFFFF, 32'hA5A5A5A5, 0,
			0, 0});
		tbl.insert(tbl.size(), '{mvs_pkg::KIND_READ, 10'd5, 31'h7FFFFFFE, 32'd0, 0, 0, 0});
		tbl.insert(tbl.size(), '{mvs_pkg::KIND_READ, 10'd5, 31'h7FFFFFFF, 32'd0, 0, 0, 0});
		// Fill key 7 to capacity, then overflow and overwrite while full.
		for (int i = 1; i <= mvs_pkg::MAX_VERSIONS; i++)
			tbl.insert(tbl.size(), '{mvs_pkg::KIND_WRITE, 10'd7, 31'(i * 10), 32'(i),
				0, 0, 0});
		tbl.insert(tbl.size(), '{mvs_pkg::KIND_WRITE, 10'd7, 31'd15, 32'd1, 1,
			mvs_pkg::ST_FULL, 32'd0});
		tbl.insert(tbl.size(), '{mvs_pkg::KIND_WRITE, 10'd7, 31'd30, 32'h55AA55AA, 0, 0, 0});
		tbl.insert(tbl.size(), '{mvs_pkg::KIND_READ, 10'd7, 31'd39, 32'd0, 0, 0, 0});
		tbl.insert(tbl.size(), '{mvs_pkg::KIND_CHECK, 10'd7, 31'd35, 32'd0, 0, 0, 0});
		foreach (tbl[i])
			send_request(tbl[i].k, tbl[i].ky, tbl[i].ts, tbl[i].wv,
				tbl[i].typed, tbl[i].st, tbl[i].rv);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			// Let everything drain once so the block runs from empty.
			if (n == 500) begin
				in_valid <= 1'b0;
				while (pending_status.size() != 0) @(posedge clk);
			end
			if (n == 300) hold_rx = 1'b1;
			rk = 2'($urandom_range(0, 2));
			if ($urandom_range(0, 40) == 0) rk = KIND_UNUSED;
			// Hot keys give full lists and same-key back-to-back requests.
			rkey = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 7)) : 10'($urandom);
			case ($urandom_range(0, 4))
				0: rts = 31'($urandom);
				1: rts = 31'h7FFFFFFF - 31'($urandom_range(0, 3));
				default: rts = 31'($urandom_range(0, 63));
			endcase
			send_request(rk, rkey, rts, $urandom, 0, 0, 0);
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Result side: random stalls, one long hold-off, and checking.
	initial begin
		int stall_left;
		hold_rx = 1'b0;
		mismatch_count = 0;
		out_stall = 1'b1;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_status.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) $display("unexpected result");
				end else begin
					if (status !== pending_status[0] || read_value !== pending_value[0]) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: status %0d/%0d value %h/%h",
								pending_status[0], status, pending_value[0], read_value);
					end
					void'(pending_status.pop_front());
					void'(pending_value.pop_front());
				end
				stall_left = $urandom_range(0, 5);
				if ($urandom_range(0, 3) == 0) stall_left = 0;
			end
			if (hold_rx) begin
				hold_rx = 1'b0;
				stall_left = 200;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// End of run.
	initial begin
		@(posedge arst_n);
		wait (stim_done);
		while (pending_status.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Timeout.
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/mvs_pkg.sv
hw/rtl/mvs_row_mem.sv
hw/rtl/mvs_update.sv
hw/rtl/mvcc_version_store_top.sv
hw/rtl/mvs_checker.sv
sim/tb_top.sv
